// ----- design/shp_pkg.sv -----
// Shared types and constants for the sync-header packet receiver.
// No dependencies; every other file of the block imports this package.
package shp_pkg;

  // Packet buffer size and derived widths
  localparam int BUFFER_DEPTH = 64;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int POS_W        = BUF_AW;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int TICK_W      = 16;
  localparam int IDX_W       = 6;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;
  localparam int                HEADER_BYTES      = 4;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_BYTE      = 2'd0,
    MODE_TICK      = 2'd1,
    MODE_READ      = 2'd2,
    MODE_TMO_CLEAR = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_SYNC_THIRD  = 2'd2,
    CFG_TIMEOUT     = 2'd3
  } cfg_reg_t;

  // Buffer write port
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  // Status flags reported with each result
  typedef struct packed {
    logic unread;
    logic timed_out;
    logic overrun;
  } item_stat_t;

endpackage

// ----- design/shp_ifs.sv -----
// Valid/ready channel interfaces of the sync-header packet receiver.
// Depends on shp_pkg for field types and widths.
interface shp_in_if;
  import shp_pkg::*;
  logic                valid;
  logic                ready;
  mode_t               mode;
  logic [BYTE_W-1:0]   rx_byte;
  logic [IDX_W-1:0]    read_index;
  modport source (output valid, mode, rx_byte, read_index, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface shp_out_if;
  import shp_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic                unread_packet;
  logic                timed_out;
  logic                overrun;
  modport source (output valid, read_data, unread_packet, timed_out, overrun, input ready);
  modport sink   (input valid, read_data, unread_packet, timed_out, overrun, output ready);
endinterface

interface shp_cfg_if;
  import shp_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/shp_ctrl.sv -----
// Packet parser, tick/timeout logic and configuration registers.
// Depends on shp_pkg; drives the buffer write port and per-request status.
module shp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  shp_pkg::cfg_reg_t             cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          accept,
  input  shp_pkg::mode_t                mode,
  input  logic [shp_pkg::BYTE_W-1:0]    rx_byte,
  output shp_pkg::buf_wr_t              buf_wr,
  output shp_pkg::item_stat_t           stat
);
  import shp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SECOND = 3'd1,
    ST_THIRD  = 3'd2,
    ST_COUNT  = 3'd3,
    ST_DATA   = 3'd4,
    ST_TRAIL  = 3'd5
  } parse_state_t;

  parse_state_t      state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic              pkt_ready_r, pkt_ready_nxt;
  logic              unread_r, unread_nxt;
  logic              overrun_r, overrun_nxt;
  logic              timeout_r, timeout_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;

  logic [BYTE_W-1:0] sync1_r, sync2_r, sync3_r;
  logic [TICK_W-1:0] tmo_ticks_r;

  logic [POS_W:0]    pos_inc;
  logic [POS_W:0]    pos_w;
  logic [TICK_W-1:0] ticks_inc;
  logic              tmo_seen;

  assign pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
  assign ticks_inc = ticks_r + TICK_W'(1);

  // Next state for one request
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pkt_ready_nxt = pkt_ready_r;
    unread_nxt    = unread_r;
    overrun_nxt   = overrun_r;
    timeout_nxt   = timeout_r;
    ticks_nxt     = ticks_r;
    pos_w         = {1'b0, pos_r};
    buf_wr.en     = 1'b0;
    buf_wr.addr   = BUF_AW'(pos_r);
    buf_wr.data   = rx_byte;

    if (accept) begin
      unique case (mode)
        MODE_BYTE: begin
          unique case (state_r)
            ST_IDLE: begin
              pos_w     = '0;
              count_nxt = '0;
              if (rx_byte == sync1_r) begin
                buf_wr.en   = 1'b1;
                buf_wr.addr = '0;
                pos_w       = (POS_W+1)'(1);
                state_nxt   = ST_SECOND;
              end
            end
            ST_SECOND: begin
              if (rx_byte == sync2_r) begin
                buf_wr.en = 1'b1;
                pos_w     = pos_inc;
                state_nxt = ST_THIRD;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            ST_THIRD: begin
              if (rx_byte == sync3_r) begin
                buf_wr.en = 1'b1;
                pos_w     = pos_inc;
                state_nxt = ST_COUNT;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            ST_COUNT: begin
              buf_wr.en = 1'b1;
              pos_w     = pos_inc;
              count_nxt = rx_byte;
              state_nxt = ST_DATA;
            end
            ST_DATA: begin
              buf_wr.en = 1'b1;
              pos_w     = pos_inc;
              if (int'(pos_inc) >= HEADER_BYTES + int'(count_r)) begin
                state_nxt = ST_TRAIL;
              end
            end
            ST_TRAIL: begin
              pkt_ready_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
          // Wrap the position at the end of the buffer and flag overrun
          if (pos_w == (POS_W+1)'(BUFFER_DEPTH)) begin
            pos_w       = '0;
            overrun_nxt = 1'b1;
          end
        end
        MODE_TICK: begin
          if (pkt_ready_r) begin
            ticks_nxt     = '0;
            pkt_ready_nxt = 1'b0;
            unread_nxt    = 1'b1;
          end else begin
            ticks_nxt = ticks_inc;
            if (ticks_inc == tmo_ticks_r) begin
              timeout_nxt = 1'b1;
            end
          end
        end
        MODE_READ: begin
          unread_nxt = 1'b0;
        end
        MODE_TMO_CLEAR: begin
        end
        default: begin
        end
      endcase
    end

    // Report the timeout flag before a clear request drops it
    tmo_seen = timeout_nxt;
    if (accept && mode == MODE_TMO_CLEAR) begin
      timeout_nxt = 1'b0;
    end
    pos_nxt = pos_w[POS_W-1:0];

    stat.unread    = unread_nxt;
    stat.timed_out = tmo_seen;
    stat.overrun   = overrun_nxt;
  end

  // Hold parser and flag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      count_r     <= '0;
      pkt_ready_r <= 1'b0;
      unread_r    <= 1'b0;
      overrun_r   <= 1'b0;
      timeout_r   <= 1'b1;
      ticks_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      pkt_ready_r <= pkt_ready_nxt;
      unread_r    <= unread_nxt;
      overrun_r   <= overrun_nxt;
      timeout_r   <= timeout_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r     <= '0;
      sync2_r     <= '0;
      sync3_r     <= '0;
      tmo_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync1_r     <= cfg_data[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync2_r     <= cfg_data[BYTE_W-1:0];
        CFG_SYNC_THIRD:  sync3_r     <= cfg_data[BYTE_W-1:0];
        CFG_TIMEOUT:     tmo_ticks_r <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/shp_buf.sv -----
// Packet buffer memory: one write port and one registered read port.
// Depends on shp_pkg for depth, address width and write port struct.
module shp_buf (
  input  logic                         clk,
  input  shp_pkg::buf_wr_t             buf_wr,
  input  logic                         rd_en,
  input  logic [shp_pkg::BUF_AW-1:0]   rd_addr,
  output logic [shp_pkg::BYTE_W-1:0]   rd_data
);
  import shp_pkg::*;

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Store received packet bytes
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/shp_pipe.sv -----
// Result pipeline: a stage aligned with the buffer read, then the output register.
// Depends on shp_pkg; produces the input ready and the accept strobe.
module shp_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       accept,
  input  logic                       rd_hit,
  input  shp_pkg::item_stat_t        stat,
  input  logic [shp_pkg::BYTE_W-1:0] rd_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [shp_pkg::BYTE_W-1:0] out_read_data,
  output shp_pkg::item_stat_t        out_stat
);
  import shp_pkg::*;

  logic              p_v_r;
  logic              p_hit_r;
  item_stat_t        p_stat_r;
  logic              o_v_r;
  logic [BYTE_W-1:0] o_data_r;
  item_stat_t        o_stat_r;
  logic              p_move;

  // Advance the first stage when the output register is free or drains
  assign p_move   = p_v_r && (!o_v_r || out_ready);
  assign in_ready = !p_v_r || p_move;
  assign accept   = in_valid && in_ready;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (accept) begin
        p_v_r <= 1'b1;
      end else if (p_move) begin
        p_v_r <= 1'b0;
      end
      if (p_move) begin
        o_v_r <= 1'b1;
      end else if (out_ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p_hit_r  <= rd_hit;
      p_stat_r <= stat;
    end
    if (p_move) begin
      o_data_r <= p_hit_r ? rd_data : '0;
      o_stat_r <= p_stat_r;
    end
  end

  assign out_valid     = o_v_r;
  assign out_read_data = o_data_r;
  assign out_stat      = o_stat_r;

endmodule

// ----- design/sync_header_packet_receiver.sv -----
// Top level of the sync-header packet receiver.
// Depends on shp_pkg, shp_ifs, shp_ctrl, shp_buf and shp_pipe.
//
//   channel   dir   handshake       payload
//   in_if     in    valid/ready     mode, rx_byte, read_index
//   out_if    out   valid/ready     read_data, unread_packet, timed_out, overrun
//   cfg_if    in    valid/ready     index, data (ready always high)
//
// One request is taken every cycle while the output is not stalled; its result
// passes through the registered read of the packet buffer and then the output register.
// Reset (rst_n low, synchronous) clears parser and flags; timeout reads set.
// A stalled output holds its result; one more request is still taken into
// the stage ahead of it, after which in_if.ready drops.
module sync_header_packet_receiver (
  input  logic     clk,
  input  logic     rst_n,
  shp_in_if.sink   in_if,
  shp_out_if.source out_if,
  shp_cfg_if.sink  cfg_if
);
  import shp_pkg::*;

  logic              accept;
  logic              in_ready;
  logic              rd_hit;
  logic [BYTE_W-1:0] rd_data;
  buf_wr_t           buf_wr;
  item_stat_t        stat;
  item_stat_t        out_stat;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;
  assign rd_hit = (in_if.mode == MODE_READ) && (int'(in_if.read_index) < BUFFER_DEPTH);

  shp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .accept    (accept),
    .mode      (in_if.mode),
    .rx_byte   (in_if.rx_byte),
    .buf_wr    (buf_wr),
    .stat      (stat)
  );

  shp_buf u_buf (
    .clk     (clk),
    .buf_wr  (buf_wr),
    .rd_en   (accept),
    .rd_addr (BUF_AW'(in_if.read_index)),
    .rd_data (rd_data)
  );

  shp_pipe u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_ready),
    .accept        (accept),
    .rd_hit        (rd_hit),
    .stat          (stat),
    .rd_data       (rd_data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_read_data (out_if.read_data),
    .out_stat      (out_stat)
  );

  assign out_if.unread_packet = out_stat.unread;
  assign out_if.timed_out     = out_stat.timed_out;
  assign out_if.overrun       = out_stat.overrun;

endmodule
